// ===== hw/rtl/rfn_pkg.sv =====
package rfn_pkg;

  // fixed field widths
  localparam int NUM_SYM        = 256;
  localparam int SYM_W          = 8;
  localparam int COUNT_W        = 32;
  localparam int TOTAL_W        = COUNT_W + SYM_W;
  localparam int OUT_W          = 15;
  localparam int SLOT_IN_W      = 14;
  localparam int SCALE_BITS_DEF = 14;

  // request kinds
  typedef enum logic [1:0] {
    KIND_LOAD      = 2'd0,
    KIND_BUILD     = 2'd1,
    KIND_READ_SYM  = 2'd2,
    KIND_READ_SLOT = 2'd3
  } kind_t;

  // frequency table write operations
  typedef enum logic [2:0] {
    FOP_NONE    = 3'd0,
    FOP_ZERO    = 3'd1,
    FOP_QUOT    = 3'd2,
    FOP_UNIFORM = 3'd3,
    FOP_DEC     = 3'd4,
    FOP_INC     = 3'd5
  } freq_op_t;

  // controller states
  typedef enum logic [4:0] {
    ST_INIT,
    ST_IDLE,
    ST_TOT_RD,
    ST_TOT_ACC,
    ST_TOT_CHK,
    ST_NRM_RD,
    ST_NRM_START,
    ST_NRM_DIV,
    ST_NRM_WR,
    ST_ADJ_CHK,
    ST_SCAN_RD,
    ST_SCAN_CMP,
    ST_ADJ_STEP,
    ST_UNI,
    ST_FILL_RD,
    ST_FILL_LOAD,
    ST_FILL_RUN,
    ST_DONE
  } state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic     accept;
    logic     mem_rd;
    logic     idx_clr;
    logic     idx_inc;
    logic     tot_acc;
    logic     set_uniform;
    logic     div_start;
    logic     div_step;
    freq_op_t freq_op;
    logic     scan_cmp;
    logic     pos_clr;
    logic     fill_load;
    logic     fill_step;
    logic     hist_clear;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic idx_last;
    logic total_zero;
    logic hist_zero;
    logic div_last;
    logic sum_gt;
    logic sum_lt;
    logic best_le1;
    logic cnt_zero;
  } stat_t;

endpackage

// ===== hw/rtl/rfn_dpath.sv =====
module rfn_dpath #(
  parameter int SCALE_BITS = rfn_pkg::SCALE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  rfn_pkg::cmd_t               cmd,
  output rfn_pkg::stat_t              stat,
  input  logic [1:0]                  in_kind,
  input  logic [rfn_pkg::SYM_W-1:0]   in_symbol,
  input  logic [rfn_pkg::COUNT_W-1:0] in_count,
  input  logic [rfn_pkg::SLOT_IN_W-1:0] in_slot,
  output logic [rfn_pkg::OUT_W-1:0]   sym_freq,
  output logic [rfn_pkg::OUT_W-1:0]   sym_start,
  output logic [rfn_pkg::SYM_W-1:0]   slot_symbol,
  output logic                        was_uniform
);
  import rfn_pkg::*;

  localparam int PS   = 1 << SCALE_BITS;
  localparam int FW   = SCALE_BITS + 1;
  localparam int SW   = SCALE_BITS + SYM_W + 1;
  localparam int RW   = TOTAL_W + SCALE_BITS + 1;
  localparam int CW   = $clog2(SCALE_BITS + 1);
  localparam logic [FW-1:0] PS_M1 = FW'(PS - 1);
  localparam logic [FW-1:0] UNI_F = FW'(PS / NUM_SYM);
  localparam logic [SW-1:0] PS_S  = SW'(PS);

  // storage
  logic [COUNT_W-1:0] hist_mem  [NUM_SYM];
  logic [FW-1:0]      freq_mem  [NUM_SYM];
  logic [OUT_W-1:0]   start_mem [NUM_SYM];
  logic [SYM_W-1:0]   slot_mem  [PS];
  logic [NUM_SYM-1:0] hist_vld;

  // working registers
  logic [SYM_W-1:0]   idx;
  logic [TOTAL_W-1:0] total;
  logic [RW-1:0]      rem;
  logic [RW-1:0]      dvs;
  logic [FW-1:0]      quo;
  logic [CW-1:0]      divcnt;
  logic [SW-1:0]      sum;
  logic [SYM_W-1:0]   best_idx;
  logic [FW-1:0]      best_val;
  logic [SW-1:0]      pos;
  logic [FW-1:0]      cnt;
  logic               wu;
  kind_t              kind_q;
  logic [FW-1:0]      freq_q;
  logic [OUT_W-1:0]   start_q;
  logic [SYM_W-1:0]   slot_q;
  logic [COUNT_W-1:0] hist_q;
  logic               hvld_q;

  kind_t              kind_in;
  logic [SYM_W-1:0]   rd_addr;
  logic [SCALE_BITS-1:0] slot_addr;
  logic [COUNT_W-1:0] hval;
  logic [FW-1:0]      fq;
  logic               ge;
  logic               freq_we;
  logic [SYM_W-1:0]   fw_addr;
  logic [FW-1:0]      fw_data;

  assign kind_in   = kind_t'(in_kind);
  assign rd_addr   = cmd.accept ? in_symbol : idx;
  assign slot_addr = SCALE_BITS'(in_slot);
  assign hval      = hvld_q ? hist_q : '0;
  assign ge        = rem >= dvs;

  // clamp the rounded quotient to 1 .. scale-1
  always_comb begin
    if (quo == '0) begin
      fq = FW'(1);
    end else if (quo > PS_M1) begin
      fq = PS_M1;
    end else begin
      fq = quo;
    end
  end

  // frequency table write selection
  always_comb begin
    freq_we = 1'b1;
    fw_addr = idx;
    fw_data = '0;
    unique case (cmd.freq_op)
      FOP_NONE:    freq_we = 1'b0;
      FOP_ZERO:    fw_data = '0;
      FOP_QUOT:    fw_data = fq;
      FOP_UNIFORM: fw_data = UNI_F;
      FOP_DEC: begin
        fw_addr = best_idx;
        fw_data = best_val - FW'(1);
      end
      FOP_INC: begin
        fw_addr = best_idx;
        fw_data = best_val + FW'(1);
      end
      default:     freq_we = 1'b0;
    endcase
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.accept && kind_in == KIND_LOAD) begin
      hist_mem[in_symbol] <= in_count;
    end
    if (freq_we) begin
      freq_mem[fw_addr] <= fw_data;
    end
    if (cmd.fill_load) begin
      start_mem[idx] <= OUT_W'(pos);
    end
    if (cmd.fill_step && pos < PS_S) begin
      slot_mem[pos[SCALE_BITS-1:0]] <= idx;
    end
    if (cmd.mem_rd) begin
      hist_q  <= hist_mem[idx];
      freq_q  <= freq_mem[rd_addr];
      start_q <= start_mem[rd_addr];
    end
    if (cmd.accept) begin
      slot_q <= slot_mem[slot_addr];
    end
  end

  // histogram valid bits, cleared at reset and after each build
  always_ff @(posedge clk) begin
    if (rst || cmd.hist_clear) begin
      hist_vld <= '0;
    end else if (cmd.accept && kind_in == KIND_LOAD) begin
      hist_vld[in_symbol] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_rd) begin
      hvld_q <= hist_vld[idx];
    end
  end

  // index, total, sum and output kind
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_q <= kind_in;
      wu     <= 1'b0;
      idx    <= '0;
      total  <= '0;
      sum    <= '0;
    end else begin
      if (cmd.idx_clr) begin
        idx <= '0;
      end else if (cmd.idx_inc) begin
        idx <= idx + SYM_W'(1);
      end
      if (cmd.tot_acc) begin
        total <= total + TOTAL_W'(hval);
      end
      if (cmd.set_uniform) begin
        wu <= 1'b1;
      end
      priority case (cmd.freq_op)
        FOP_QUOT: sum <= sum + SW'(fq);
        FOP_DEC:  sum <= sum - SW'(1);
        FOP_INC:  sum <= sum + SW'(1);
        default:  sum <= sum;
      endcase
    end
  end

  // restoring divider, one quotient bit a cycle
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      rem    <= (RW'(hval) << SCALE_BITS) + RW'(total >> 1);
      dvs    <= RW'(total) << SCALE_BITS;
      quo    <= '0;
      divcnt <= CW'(SCALE_BITS);
    end else if (cmd.div_step) begin
      if (ge) begin
        rem <= rem - dvs;
      end
      quo    <= {quo[FW-2:0], ge};
      dvs    <= dvs >> 1;
      divcnt <= divcnt - CW'(1);
    end
  end

  // largest entry search, lowest index wins ties
  always_ff @(posedge clk) begin
    if (cmd.scan_cmp && (idx == '0 || freq_q > best_val)) begin
      best_idx <= idx;
      best_val <= freq_q;
    end
  end

  // slot fill walker
  always_ff @(posedge clk) begin
    if (cmd.pos_clr) begin
      pos <= '0;
    end else if (cmd.fill_step) begin
      if (pos < PS_S) begin
        pos <= pos + SW'(1);
      end else begin
        pos <= pos + SW'(cnt);
      end
    end
    if (cmd.fill_load) begin
      cnt <= freq_q;
    end else if (cmd.fill_step) begin
      if (pos < PS_S) begin
        cnt <= cnt - FW'(1);
      end else begin
        cnt <= '0;
      end
    end
  end

  // status
  assign stat.idx_last   = idx == SYM_W'(NUM_SYM - 1);
  assign stat.total_zero = total == '0;
  assign stat.hist_zero  = hval == '0;
  assign stat.div_last   = divcnt == '0;
  assign stat.sum_gt     = sum > PS_S;
  assign stat.sum_lt     = sum < PS_S;
  assign stat.best_le1   = best_val <= FW'(1);
  assign stat.cnt_zero   = cnt == '0;

  // result fields
  assign sym_freq    = (kind_q == KIND_READ_SYM)  ? OUT_W'(freq_q) : '0;
  assign sym_start   = (kind_q == KIND_READ_SYM)  ? start_q : '0;
  assign slot_symbol = (kind_q == KIND_READ_SLOT) ? slot_q : '0;
  assign was_uniform = (kind_q == KIND_BUILD)     ? wu : 1'b0;

endmodule

// ===== hw/rtl/rfn_ctrl.sv =====
module rfn_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           s_tvalid,
  output logic           s_tready,
  input  logic [1:0]     s_kind,
  output logic           m_tvalid,
  input  logic           m_tready,
  output rfn_pkg::cmd_t  cmd,
  input  rfn_pkg::stat_t stat
);
  import rfn_pkg::*;

  state_t state, state_next;
  logic   report;
  logic   take;
  kind_t  kind_in;

  assign kind_in = kind_t'(s_kind);
  assign take    = s_tvalid && s_tready;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_INIT;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_INIT: begin
        cmd.idx_clr = 1'b1;
        state_next  = ST_UNI;
      end
      ST_IDLE: begin
        s_tready = !m_tvalid || m_tready;
        if (s_tvalid && s_tready) begin
          cmd.accept = 1'b1;
          cmd.mem_rd = 1'b1;
          if (kind_in == KIND_BUILD) begin
            state_next = ST_TOT_RD;
          end
        end
      end
      ST_TOT_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_TOT_ACC;
      end
      ST_TOT_ACC: begin
        cmd.tot_acc = 1'b1;
        cmd.idx_inc = 1'b1;
        state_next  = stat.idx_last ? ST_TOT_CHK : ST_TOT_RD;
      end
      ST_TOT_CHK: begin
        if (stat.total_zero) begin
          cmd.set_uniform = 1'b1;
          state_next      = ST_UNI;
        end else begin
          state_next = ST_NRM_RD;
        end
      end
      ST_NRM_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_NRM_START;
      end
      ST_NRM_START: begin
        if (stat.hist_zero) begin
          cmd.freq_op = FOP_ZERO;
          cmd.idx_inc = 1'b1;
          state_next  = stat.idx_last ? ST_ADJ_CHK : ST_NRM_RD;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = ST_NRM_DIV;
        end
      end
      ST_NRM_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_NRM_WR;
        end
      end
      ST_NRM_WR: begin
        cmd.freq_op = FOP_QUOT;
        cmd.idx_inc = 1'b1;
        state_next  = stat.idx_last ? ST_ADJ_CHK : ST_NRM_RD;
      end
      ST_ADJ_CHK: begin
        if (stat.sum_gt || stat.sum_lt) begin
          state_next = ST_SCAN_RD;
        end else begin
          cmd.pos_clr = 1'b1;
          state_next  = ST_FILL_RD;
        end
      end
      ST_SCAN_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_SCAN_CMP;
      end
      ST_SCAN_CMP: begin
        cmd.scan_cmp = 1'b1;
        cmd.idx_inc  = 1'b1;
        state_next   = stat.idx_last ? ST_ADJ_STEP : ST_SCAN_RD;
      end
      ST_ADJ_STEP: begin
        if (stat.sum_gt) begin
          if (stat.best_le1) begin
            cmd.pos_clr = 1'b1;
            state_next  = ST_FILL_RD;
          end else begin
            cmd.freq_op = FOP_DEC;
            state_next  = ST_ADJ_CHK;
          end
        end else begin
          cmd.freq_op = FOP_INC;
          state_next  = ST_ADJ_CHK;
        end
      end
      ST_UNI: begin
        cmd.freq_op = FOP_UNIFORM;
        cmd.idx_inc = 1'b1;
        if (stat.idx_last) begin
          cmd.pos_clr = 1'b1;
          state_next  = ST_FILL_RD;
        end
      end
      ST_FILL_RD: begin
        cmd.mem_rd = 1'b1;
        state_next = ST_FILL_LOAD;
      end
      ST_FILL_LOAD: begin
        cmd.fill_load = 1'b1;
        state_next    = ST_FILL_RUN;
      end
      ST_FILL_RUN: begin
        if (stat.cnt_zero) begin
          cmd.idx_inc = 1'b1;
          state_next  = stat.idx_last ? ST_DONE : ST_FILL_RD;
        end else begin
          cmd.fill_step = 1'b1;
        end
      end
      ST_DONE: begin
        cmd.hist_clear = 1'b1;
        state_next     = ST_IDLE;
      end
      default: state_next = ST_INIT;
    endcase
  end

  // result valid and build report flag
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      report   <= 1'b0;
    end else begin
      if (state == ST_IDLE && take && kind_in != KIND_BUILD) begin
        m_tvalid <= 1'b1;
      end else if (state == ST_DONE && report) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      if (state == ST_IDLE && take && kind_in == KIND_BUILD) begin
        report <= 1'b1;
      end else if (state == ST_DONE) begin
        report <= 1'b0;
      end
    end
  end

  // checks
  a_no_take_on_stall: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s_tready)
    else $error("request taken while result stalled");

  a_build_goes_busy: assert property (@(posedge clk) disable iff (rst)
    (take && kind_in == KIND_BUILD) |=> (state != ST_IDLE && !m_tvalid))
    else $error("build did not start");

  a_build_reports: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DONE && report) |=> (m_tvalid && state == ST_IDLE))
    else $error("build result not presented");

  a_lookup_result: assert property (@(posedge clk) disable iff (rst)
    (take && kind_in != KIND_BUILD) |=> m_tvalid)
    else $error("lookup result missing");

endmodule

// ===== hw/rtl/rans_frequency_normalizer.sv =====
// rANS byte-model frequency table builder.
// Slave channel: s_tuser carries the request kind (load, build, symbol read,
// slot read); s_tdata carries symbol, count and slot. Master channel: one
// result per request, m_tdata with frequency, start, slot symbol and the
// uniform flag.
// Loads and lookups: one request a cycle while no result is stalled, result
// in the cycle after acceptance from the registered memory reads.
// Build: the block is busy until the tables are rebuilt: a pass over the
// histogram for the total, then a pass that sets empty symbols to zero and
// scales each seen symbol with the one-bit-a-cycle divider, then a full
// pass over the frequency table per unit of sum correction, then a pass
// over the symbols and slots (2^SCALE_BITS) for the slot table write port.
// The build result follows the fill through the done state.
// Reset: the histogram is cleared at once; the tables are rebuilt as the
// uniform table with s_tready low.
// A stalled result holds m_tdata; one new request is taken in the cycle the
// pending result is taken, none while it is stalled.
module rans_frequency_normalizer #(
  parameter int SCALE_BITS = rfn_pkg::SCALE_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // symbol[7:0], count[39:8], slot[53:40]
  input  logic [1:0]  s_tuser,   // kind[1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata    // sym_freq[14:0], sym_start[29:15],
                                 // slot_symbol[37:30], was_uniform[38]
);
  import rfn_pkg::*;

  cmd_t             cmd;
  stat_t            stat;
  logic [OUT_W-1:0] sym_freq;
  logic [OUT_W-1:0] sym_start;
  logic [SYM_W-1:0] slot_symbol;
  logic             was_uniform;

  // control
  rfn_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_kind   (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd),
    .stat     (stat)
  );

  // tables and arithmetic
  rfn_dpath #(
    .SCALE_BITS (SCALE_BITS)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .in_kind     (s_tuser),
    .in_symbol   (s_tdata[7:0]),
    .in_count    (s_tdata[39:8]),
    .in_slot     (s_tdata[53:40]),
    .sym_freq    (sym_freq),
    .sym_start   (sym_start),
    .slot_symbol (slot_symbol),
    .was_uniform (was_uniform)
  );

  // result packing
  assign m_tdata = {1'b0, was_uniform, slot_symbol, sym_start, sym_freq};

endmodule

// ===== dv/rans_frequency_normalizer_tb.sv =====
`timescale 1ns / 100ps

module rans_frequency_normalizer_tb;
  import rfn_pkg::*;

  localparam int SCALE     = 1 << SCALE_BITS_DEF;
  localparam int UNI_FREQ  = SCALE / NUM_SYM;
  localparam int LIMIT     = 50_000_000;
  localparam int SETTLE    = 40;

  typedef struct packed {
    logic             uniform;
    logic [SYM_W-1:0] owner;
    logic [OUT_W-1:0] start;
    logic [OUT_W-1:0] freq;
  } lookup_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [55:0] s_tdata = '0;
  logic [1:0]  s_tuser = KIND_LOAD;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [39:0] m_tdata;

  // shadow copy of the block state
  logic [COUNT_W-1:0] hist_sh [NUM_SYM];
  int unsigned        freq_sh [NUM_SYM];
  int unsigned        start_sh [NUM_SYM];
  logic [SYM_W-1:0]   owner_sh [SCALE];

  lookup_t     pending_q [$];
  int          errors = 0;
  int          cycles = 0;
  int          rdy_hold = 0;
  bit          calm = 1'b0;
  int          n_req = 0, n_build = 0, n_uni = 0, n_seen = 0;

  rans_frequency_normalizer dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  always #6 clk = ~clk;

  // cumulative starts and slot owners from the frequency table
  function automatic void fill_slots();
    int unsigned pos;
    pos = 0;
    for (int s = 0; s < NUM_SYM; s++) begin
      start_sh[s] = pos;
      for (int unsigned i = 0; i < freq_sh[s]; i++)
        if (pos + i < SCALE) owner_sh[pos + i] = s[SYM_W-1:0];
      pos += freq_sh[s];
    end
  endfunction

  function automatic void make_uniform();
    for (int s = 0; s < NUM_SYM; s++) freq_sh[s] = UNI_FREQ;
    fill_slots();
  endfunction

  function automatic int largest_sym();
    int b;
    b = 0;
    for (int s = 1; s < NUM_SYM; s++) if (freq_sh[s] > freq_sh[b]) b = s;
    return b;
  endfunction

  // scale the histogram to the probability total; returns 1 for an empty histogram
  function automatic bit normalise_hist();
    longint unsigned total, sum, f;
    int b;
    total = 0;
    sum = 0;
    for (int s = 0; s < NUM_SYM; s++) total += hist_sh[s];
    if (total == 0) begin
      make_uniform();
      return 1'b1;
    end
    for (int s = 0; s < NUM_SYM; s++) begin
      if (hist_sh[s] == 0) begin
        freq_sh[s] = 0;
      end else begin
        f = (longint'(hist_sh[s]) * SCALE + total / 2) / total;
        if (f == 0) f = 1;
        if (f > SCALE - 1) f = SCALE - 1;
        freq_sh[s] = 32'(f);
        sum += f;
      end
    end
    while (sum > SCALE) begin
      b = largest_sym();
      if (freq_sh[b] <= 1) break;
      freq_sh[b]--;
      sum--;
    end
    while (sum < SCALE) begin
      b = largest_sym();
      freq_sh[b]++;
      sum++;
    end
    fill_slots();
    return 1'b0;
  endfunction

  function automatic lookup_t predict_lookup(kind_t kind, logic [7:0] sym,
                                             logic [31:0] cnt, logic [13:0] slot);
    lookup_t r;
    r = '0;
    case (kind)
      KIND_LOAD: begin
        hist_sh[sym] = cnt;
      end
      KIND_BUILD: begin
        r.uniform = normalise_hist();
        for (int s = 0; s < NUM_SYM; s++) hist_sh[s] = '0;
      end
      KIND_READ_SYM: begin
        r.freq  = freq_sh[sym][OUT_W-1:0];
        r.start = start_sh[sym][OUT_W-1:0];
      end
      default: begin
        r.owner = owner_sh[slot & (SCALE - 1)];
      end
    endcase
    return r;
  endfunction

  // one request; valid stays high until the caller idles or a random gap drops it
  task automatic send(kind_t kind, logic [7:0] sym, logic [31:0] cnt, logic [13:0] slot);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {2'b00, slot, cnt, sym};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pending_q.push_back(predict_lookup(kind, sym, cnt, slot));
    n_req++;
    if (kind == KIND_BUILD) n_build++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
  endtask

  task automatic drain();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
  endtask

  // result checker
  always @(posedge clk) begin
    lookup_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got = m_tdata[38:0];
      n_seen++;
      if (pending_q.size() == 0) begin
        $error("result with nothing pending: %h", m_tdata);
        errors++;
      end else begin
        want = pending_q.pop_front();
        if (want.uniform) n_uni++;
        if (got.freq !== want.freq) begin
          $error("sym_freq expected %0d got %0d", want.freq, got.freq);
          errors++;
        end
        if (got.start !== want.start) begin
          $error("sym_start expected %0d got %0d", want.start, got.start);
          errors++;
        end
        if (got.owner !== want.owner) begin
          $error("slot_symbol expected %0d got %0d", want.owner, got.owner);
          errors++;
        end
        if (got.uniform !== want.uniform) begin
          $error("was_uniform expected %0d got %0d", want.uniform, got.uniform);
          errors++;
        end
      end
    end
  end

  // receiver stalls in bursts
  always @(posedge clk) begin
    if (rst || calm) begin
      m_tready <= 1'b1;
      rdy_hold <= 0;
    end else if (rdy_hold > 0) begin
      rdy_hold <= rdy_hold - 1;
      m_tready <= 1'b0;
    end else if ($urandom_range(0, 6) == 0) begin
      rdy_hold <= $urandom_range(0, 4);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  function automatic logic [31:0] rand_count();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'd1;
      2: return 32'hFFFF_FFFF;
      3: return $urandom_range(1, 100);
      default: return $urandom;
    endcase
  endfunction

  // lookups of the extreme entries
  task automatic read_extremes();
    send(KIND_READ_SYM, 8'd0, 32'd0, 14'd0);
    send(KIND_READ_SYM, 8'd255, 32'd0, 14'd0);
    send(KIND_READ_SLOT, 8'd0, 32'd0, 14'd0);
    send(KIND_READ_SLOT, 8'd0, 32'd0, 14'h3FFF);
  endtask

  task automatic test_reset_tables();
    read_extremes();
    send(KIND_READ_SYM, 8'd128, 32'hFFFF_FFFF, 14'h3FFF);
  endtask

  // one symbol alone hits the upper clamp and is stepped back up
  task automatic test_single_symbol();
    send(KIND_LOAD, 8'd255, 32'hFFFF_FFFF, 14'h3FFF);
    send(KIND_BUILD, 8'd0, 32'd0, 14'd0);
    read_extremes();
  endtask

  // a load replaces the count; a tiny count next to a huge one gets 1
  task automatic test_overwrite_and_floor();
    send(KIND_LOAD, 8'd0, 32'd5000, 14'd0);
    send(KIND_LOAD, 8'd0, 32'hFFFF_FFFF, 14'd0);
    send(KIND_LOAD, 8'd7, 32'd1, 14'd0);
    send(KIND_BUILD, 8'd0, 32'd0, 14'd0);
    send(KIND_READ_SYM, 8'd7, 32'd0, 14'd0);
    read_extremes();
  endtask

  // empty histogram after a build gives the uniform table
  task automatic test_empty_build();
    drain();
    send(KIND_BUILD, 8'd0, 32'd0, 14'd0);
    send(KIND_READ_SYM, 8'd200, 32'd0, 14'd0);
    send(KIND_READ_SLOT, 8'd0, 32'd0, 14'd12800);
  endtask

  // loads of random content, a build, then lookups; some noise mixed in
  task automatic test_random_builds(int target);
    int nload;
    while (n_req < target) begin
      if (n_req > target - 60) calm = 1'b1;
      if ($urandom_range(0, 9) < 7) begin
        nload = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
        repeat (nload) send(KIND_LOAD, 8'($urandom), rand_count(), 14'($urandom));
        send(KIND_BUILD, 8'($urandom), $urandom, 14'($urandom));
        repeat ($urandom_range(4, 12))
          send($urandom_range(0, 1) ? KIND_READ_SYM : KIND_READ_SLOT,
               8'($urandom), $urandom, 14'($urandom));
      end else begin
        repeat ($urandom_range(1, 6))
          send(kind_t'($urandom_range(0, 20) == 0 ? KIND_BUILD :
                       ($urandom_range(0, 2) == 0 ? KIND_LOAD :
                        ($urandom_range(0, 1) ? KIND_READ_SYM : KIND_READ_SLOT))),
               8'($urandom), rand_count(), 14'($urandom));
      end
      if ($urandom_range(0, 15) == 0) drain();
    end
  endtask

  initial begin
    for (int s = 0; s < NUM_SYM; s++) hist_sh[s] = '0;
    make_uniform();
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_tables();
    test_single_symbol();
    test_overwrite_and_floor();
    test_empty_build();
    test_random_builds(400);
    drain();
    repeat (SETTLE) @(posedge clk);
    $display("covered %0d requests and %0d results with %0d table builds (%0d uniform)",
             n_req, n_seen, n_build, n_uni);
    $display("loads, symbol and slot lookups under random stalls on both sides");
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/rfn_pkg.sv
hw/rtl/rfn_dpath.sv
hw/rtl/rfn_ctrl.sv
hw/rtl/rans_frequency_normalizer.sv
dv/rans_frequency_normalizer_tb.sv
